@@ rtl/nps2d_pkg.sv @@
// Package for the two-dimensional nearest point search unit.
// Holds the fixed field widths and the item struct types; depends on nothing.
package nps2d_pkg;

	// Fixed field widths of the item formats.
	localparam int COORD_BITS = 24;
	localparam int SLOT_W     = 6;
	localparam int TAG_W      = 32;

	// A squared coordinate difference, the reported squared distance and its root.
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int SUM_W  = 50;
	localparam int ROOT_W = SUM_W / 2;

	// Item kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic                         kind;
		logic [SLOT_W-1:0]            slot;
		logic signed [COORD_BITS-1:0] latitude;
		logic signed [COORD_BITS-1:0] longitude;
		logic [TAG_W-1:0]             order_tag;
	} in_item_t;

	typedef struct packed {
		logic [TAG_W-1:0]  result_tag;
		logic              found;
		logic [SLOT_W-1:0] nearest_slot;
		logic [SUM_W-1:0]  distance_squared;
		logic [ROOT_W-1:0] distance;
	} out_item_t;

endpackage

@@ rtl/nps2d_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package needed.
module nps2d_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/nps2d_sqrt.sv @@
// Iterative floor square root, one result bit per cycle (restoring method).
// Depends on nps2d_pkg for the radicand and root widths.
module nps2d_sqrt import nps2d_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  radicand,
	output logic              busy,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [SUM_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [REM_W-1:0] shifted;
	logic [REM_W-1:0] trial;
	logic             take;

	// Bring down the next two radicand bits and try the next root bit.
	always_comb begin
		shifted = {rem_q[REM_W-3:0], rad_q[SUM_W-1 -: 2]};
		trial   = REM_W'({root_q, 2'b01});
		take    = (shifted >= trial);
	end

	// Control: count one step per cycle after start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ROOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: remainder, partial root and radicand shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= take ? (shifted - trial) : shifted;
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

	// A finished root always came from a full count of steps.
	a_done_after_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(cnt_q) == CNT_W'(1))
		else $error("square root finished before its last step");

endmodule

@@ rtl/nearest_point_search_2d_unit.sv @@
// Top level of the two-dimensional nearest point search unit.
// Uses nps2d_pkg, nps2d_ram (point table) and nps2d_sqrt (final root).
//
//  channel   direction  handshake               payload
//  in        to block   in_valid / in_ready     in_data  (in_item_t)
//  out       from block out_valid / out_ready   out_data (out_item_t)
//
// A query item scans the table one slot per cycle through the shared
// subtract / square / add / compare pipeline, then runs a ROOT_W step
// square root. The block takes no item while a query is in work; loads are
// taken while a result waits on out. Reset clears all valid marks at once;
// table contents are not cleared. A stalled out channel holds the next query
// at its end.
module nearest_point_search_2d_unit import nps2d_pkg::*; #(
	parameter int TABLE_SLOTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W  = IDX_W + 1;
	localparam int PIPE_N = 5;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_ROOT  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	logic                    in_fire;
	logic                    load_fire;
	logic                    query_fire;
	logic                    slot_in_range;
	logic [IDX_W-1:0]        load_idx;

	logic [TABLE_SLOTS-1:0]  valid_q;
	logic [CNT_W-1:0]        scan_q;
	logic [IDX_W-1:0]        scan_idx;
	logic                    last_slot;

	logic signed [COORD_BITS-1:0] qlat_q;
	logic signed [COORD_BITS-1:0] qlon_q;
	logic [TAG_W-1:0]             tag_q;

	logic [2*COORD_BITS-1:0] rd_data;
	logic [COORD_BITS-1:0]   rd_lat;
	logic [COORD_BITS-1:0]   rd_lon;

	logic [PIPE_N-1:0]       live_q;
	logic                    hit_s1, hit_s2, hit_s3, hit_s4, hit_s5;
	logic [IDX_W-1:0]        idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [COORD_BITS-1:0]   mag_lat_s2, mag_lon_s2, mag_lon_s3;
	logic [SQ_W-1:0]         sq_lat_s3, sq_lat_s4, sq_lon_s4;
	logic [SUM_W-1:0]        sum_s5;

	logic signed [COORD_BITS:0] dlat;
	logic signed [COORD_BITS:0] dlon;
	logic [COORD_BITS-1:0]      mag_lat;
	logic [COORD_BITS-1:0]      mag_lon;

	logic                    have_q;
	logic [SUM_W-1:0]        best_q;
	logic [IDX_W-1:0]        best_idx_q;

	logic                    root_start;
	logic                    root_busy;
	logic [ROOT_W-1:0]       root;

	logic                    out_valid_q;
	out_item_t               out_q;
	logic                    out_free;

	// Input handshake and item decoding.
	assign in_ready      = (state_q == S_IDLE);
	assign in_fire       = in_valid && in_ready;
	assign slot_in_range = (32'(in_data.slot) < 32'(TABLE_SLOTS));
	assign load_fire     = in_fire && (in_data.kind == KIND_LOAD) && slot_in_range;
	assign query_fire    = in_fire && (in_data.kind == KIND_QUERY);
	assign load_idx      = IDX_W'(in_data.slot);

	assign scan_idx   = scan_q[IDX_W-1:0];
	assign last_slot  = (scan_q == CNT_W'(TABLE_SLOTS - 1));
	assign root_start = (state_q == S_DRAIN) && (live_q == '0);
	assign out_free   = !out_valid_q || out_ready;

	// Point table: latitude in the upper half, longitude in the lower half.
	nps2d_ram #(
		.WIDTH (2 * COORD_BITS),
		.DEPTH (TABLE_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (load_fire),
		.waddr (load_idx),
		.wdata ({in_data.latitude, in_data.longitude}),
		.raddr (scan_idx),
		.rdata (rd_data)
	);

	assign rd_lat = rd_data[2*COORD_BITS-1:COORD_BITS];
	assign rd_lon = rd_data[COORD_BITS-1:0];

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					scan_q <= '0;
					if (query_fire) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					scan_q <= scan_q + CNT_W'(1);
					if (last_slot) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (root_start) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (!root_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Valid marks, cleared at reset and set by each load to an in-range slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (load_fire) begin
			valid_q[load_idx] <= 1'b1;
		end
	end

	// Query position and tag.
	always_ff @(posedge clk) begin
		if (query_fire) begin
			qlat_q <= in_data.latitude;
			qlon_q <= in_data.longitude;
			tag_q  <= in_data.order_tag;
		end
	end

	// Occupancy of the distance pipeline, used to wait for it to empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else begin
			live_q <= {live_q[PIPE_N-2:0], state_q == S_SCAN};
		end
	end

	// Stage 1 work: signed differences and their magnitudes.
	always_comb begin
		dlat    = $signed({rd_lat[COORD_BITS-1], rd_lat}) - $signed({qlat_q[COORD_BITS-1], qlat_q});
		dlon    = $signed({rd_lon[COORD_BITS-1], rd_lon}) - $signed({qlon_q[COORD_BITS-1], qlon_q});
		mag_lat = dlat[COORD_BITS] ? COORD_BITS'(-dlat) : dlat[COORD_BITS-1:0];
		mag_lon = dlon[COORD_BITS] ? COORD_BITS'(-dlon) : dlon[COORD_BITS-1:0];
	end

	// Distance pipeline: read, magnitudes, square, square, sum.
	always_ff @(posedge clk) begin
		hit_s1     <= (state_q == S_SCAN) && valid_q[scan_idx];
		idx_s1     <= scan_idx;

		hit_s2     <= hit_s1;
		idx_s2     <= idx_s1;
		mag_lat_s2 <= mag_lat;
		mag_lon_s2 <= mag_lon;

		hit_s3     <= hit_s2;
		idx_s3     <= idx_s2;
		sq_lat_s3  <= mag_lat_s2 * mag_lat_s2;
		mag_lon_s3 <= mag_lon_s2;

		hit_s4     <= hit_s3;
		idx_s4     <= idx_s3;
		sq_lat_s4  <= sq_lat_s3;
		sq_lon_s4  <= mag_lon_s3 * mag_lon_s3;

		hit_s5     <= hit_s4;
		idx_s5     <= idx_s4;
		sum_s5     <= SUM_W'(sq_lat_s4) + SUM_W'(sq_lon_s4);
	end

	// Running best; a strict compare keeps the lowest slot on ties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (query_fire) begin
			have_q     <= 1'b0;
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (hit_s5 && (!have_q || (sum_s5 < best_q))) begin
			have_q     <= 1'b1;
			best_q     <= sum_s5;
			best_idx_q <= idx_s5;
		end
	end

	// Floor square root of the winning squared distance.
	nps2d_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (best_q),
		.busy     (root_busy),
		.root     (root)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q.result_tag       <= tag_q;
			out_q.found            <= have_q;
			out_q.nearest_slot     <= SLOT_W'(best_idx_q);
			out_q.distance_squared <= best_q;
			out_q.distance         <= root;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The best distance never grows during a scan.
	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		have_q && (state_q == S_SCAN || state_q == S_DRAIN) |=> best_q <= $past(best_q))
		else $error("best distance grew during a scan");

	// The root starts only once the distance pipeline is empty.
	a_root_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		root_start |-> live_q == '0 && !hit_s5)
		else $error("square root started with the pipeline still busy");

	// A found slot is always a valid one.
	a_found_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && have_q |-> valid_q[best_idx_q])
		else $error("reported slot is not valid");

	// No item is taken while the distance pipeline or the root is in work.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		root_busy || live_q != '0 |-> !in_fire)
		else $error("item taken while a query was in work");

endmodule
